FILE: src/ghash_pkg.sv
// Shared types and constants for the GHASH accumulator.
package ghash_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_HIGH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUBKEY_LOW  = 1'd1;

  // Input opcodes (code 3 means nothing and is dropped)
  localparam logic [1:0] OP_AAD   = 2'd0;
  localparam logic [1:0] OP_TEXT  = 2'd1;
  localparam logic [1:0] OP_FINAL = 2'd2;

  localparam int unsigned BLK_BYTES = 16;
  localparam int unsigned TOTAL_W   = 61;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [63:0] block_high;
    logic [63:0] block_low;
    logic [4:0]  valid_bytes;
  } in_item_t;

  typedef struct packed {
    logic [63:0] hash_high;
    logic [63:0] hash_low;
  } out_item_t;

  // Item held in the input register, already padded
  typedef struct packed {
    logic         fin;
    logic         is_aad;
    logic [127:0] data;
    logic [4:0]   nbytes;
  } stage_item_t;

  // Status from the core toward the top level
  typedef struct packed {
    logic         res_valid;
    logic [127:0] res_hash;
  } core_res_t;

endpackage

FILE: src/ghash_gfmul.sv
// GF(2^128) multiplier in GCM bit order (bit 127 is coefficient x^0).
module ghash_gfmul (
  input  logic [127:0] a,
  input  logic [127:0] b,
  output logic [127:0] p
);

  logic [127:0] ar;
  logic [127:0] br;
  logic [254:0] c;
  logic [126:0] h;
  logic [134:0] r;
  logic [6:0]   g;
  logic [127:0] red;

  always_comb begin
    // reflect into plain polynomial order
    for (int k = 0; k < 128; k++) begin
      ar[k] = a[127-k];
      br[k] = b[127-k];
    end
    // carry-less product, one shifted copy per set bit
    c = '0;
    for (int i = 0; i < 128; i++) begin
      if (ar[i]) begin
        c = c ^ ({127'b0, br} << i);
      end
    end
    // fold high half with x^128 = x^7 + x^2 + x + 1, twice
    h = c[254:128];
    r = {7'b0, c[127:0]} ^ {8'b0, h} ^ ({8'b0, h} << 1) ^ ({8'b0, h} << 2)
        ^ ({8'b0, h} << 7);
    g = r[134:128];
    red = r[127:0] ^ {121'b0, g} ^ ({121'b0, g} << 1) ^ ({121'b0, g} << 2)
          ^ ({121'b0, g} << 7);
    for (int k = 0; k < 128; k++) begin
      p[k] = red[127-k];
    end
  end

endmodule

FILE: src/ghash_in_stage.sv
// Input register: takes a transaction, zero-pads the block, drops no-op items.
module ghash_in_stage (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  ghash_pkg::in_item_t    in_data,
  input  logic                   adv,
  output logic                   s1_valid,
  output ghash_pkg::stage_item_t s1_item
);
  import ghash_pkg::*;

  logic        s1_valid_r;
  logic        s1_valid_nxt;
  stage_item_t s1_item_r;
  stage_item_t s1_item_nxt;
  logic        accept;
  logic        keep;
  logic [4:0]  n_clamp;
  logic [127:0] mask;

  assign in_ready = !s1_valid_r || adv;
  assign accept   = in_valid && in_ready;

  // Clamp count and build leading-byte mask
  always_comb begin
    n_clamp = (in_data.valid_bytes > 5'(BLK_BYTES)) ? 5'(BLK_BYTES) : in_data.valid_bytes;
    for (int b = 0; b < BLK_BYTES; b++) begin
      mask[127-8*b -: 8] = (5'(b) < n_clamp) ? 8'hFF : 8'h00;
    end
  end

  // Finalize always kept; data needs a nonzero count; code 3 dropped
  always_comb begin
    case (in_data.opcode) inside
      OP_FINAL:        keep = 1'b1;
      OP_AAD, OP_TEXT: keep = (in_data.valid_bytes != 5'd0);
      default:         keep = 1'b0;
    endcase
  end

  always_comb begin
    s1_item_nxt.fin    = (in_data.opcode == OP_FINAL);
    s1_item_nxt.is_aad = (in_data.opcode == OP_AAD);
    s1_item_nxt.data   = {in_data.block_high, in_data.block_low} & mask;
    s1_item_nxt.nbytes = n_clamp;
    if (accept) begin
      s1_valid_nxt = keep;
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item_r <= s1_item_nxt;
    end
  end

  assign s1_valid = s1_valid_r;
  assign s1_item  = s1_item_r;

endmodule

FILE: src/ghash_core.sv
// Accumulator, byte totals and the per-item multiply by H.
module ghash_core (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   s1_valid,
  input  ghash_pkg::stage_item_t s1_item,
  input  logic [127:0]           subkey,
  input  logic                   out_busy,
  output logic                   adv,
  output ghash_pkg::core_res_t   res
);
  import ghash_pkg::*;

  logic [127:0]       acc_r;
  logic [127:0]       acc_nxt;
  logic [TOTAL_W-1:0] aad_tot_r;
  logic [TOTAL_W-1:0] aad_tot_nxt;
  logic [TOTAL_W-1:0] text_tot_r;
  logic [TOTAL_W-1:0] text_tot_nxt;
  logic [127:0]       x;
  logic [127:0]       prod;

  // finalize waits only for a free output register
  assign adv = s1_valid && !(s1_item.fin && out_busy);

  // length block: totals in bits, big-endian
  assign x = s1_item.fin ? {aad_tot_r, 3'b000, text_tot_r, 3'b000} : s1_item.data;

  ghash_gfmul u_gfmul (
    .a (acc_r ^ x),
    .b (subkey),
    .p (prod)
  );

  always_comb begin
    acc_nxt      = acc_r;
    aad_tot_nxt  = aad_tot_r;
    text_tot_nxt = text_tot_r;
    if (adv) begin
      if (s1_item.fin) begin
        acc_nxt      = '0;
        aad_tot_nxt  = '0;
        text_tot_nxt = '0;
      end else begin
        acc_nxt = prod;
        if (s1_item.is_aad) begin
          aad_tot_nxt = aad_tot_r + TOTAL_W'(s1_item.nbytes);
        end else begin
          text_tot_nxt = text_tot_r + TOTAL_W'(s1_item.nbytes);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r      <= '0;
      aad_tot_r  <= '0;
      text_tot_r <= '0;
    end else begin
      acc_r      <= acc_nxt;
      aad_tot_r  <= aad_tot_nxt;
      text_tot_r <= text_tot_nxt;
    end
  end

  assign res.res_valid = adv && s1_item.fin;
  assign res.res_hash  = prod;

endmodule

FILE: src/ghash_gf128_accumulator_unit.sv
// Top level of the GCM GHASH accumulator.
//
// Usage:
//   Load hash subkey H through cfg_we/cfg_index/cfg_wdata (index 0 upper
//   64 bits, index 1 lower 64 bits) while the block is idle.
//   Send AAD (opcode 0) and ciphertext (opcode 1) blocks on in_valid/in_ready;
//   bytes past valid_bytes are zeroed; only the valid bytes (up to 16) count.
//   A finalize transaction (opcode 2) folds in the length block, returns the
//   hash on out_valid/out_ready and clears accumulator and totals.
// Throughput and pipeline:
//   One transaction per cycle, except that a finalize waits while an earlier
//   hash is still untaken. A finalize result passes the input register, then
//   the output register, before it shows on out_valid.
//   The rate is set by the combinational GF(2^128) multiply in the
//   accumulator feedback loop.
// Reset: synchronous, clears subkey, accumulator, totals and all valids.
// Stall: while a hash waits on out_ready, data blocks keep flowing; a
//   second finalize holds in the input register, dropping in_ready.
module ghash_gf128_accumulator_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  ghash_pkg::in_item_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output ghash_pkg::out_item_t                out_data,
  input  logic                                cfg_we,
  input  logic [ghash_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [63:0]                         cfg_wdata
);
  import ghash_pkg::*;

  logic [63:0] subkey_high_r;
  logic [63:0] subkey_low_r;
  logic        s1_valid;
  stage_item_t s1_item;
  logic        adv;
  core_res_t   res;
  logic        out_valid_r;
  logic        out_valid_nxt;
  out_item_t   out_data_r;
  logic        out_busy;

  // Subkey registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subkey_high_r <= '0;
      subkey_low_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SUBKEY_HIGH: subkey_high_r <= cfg_wdata;
        REG_SUBKEY_LOW:  subkey_low_r  <= cfg_wdata;
        default:         subkey_low_r  <= subkey_low_r;
      endcase
    end
  end

  ghash_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .adv      (adv),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // output register still holds a hash that is not taken this cycle
  assign out_busy = out_valid_r && !out_ready;

  ghash_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .s1_valid (s1_valid),
    .s1_item  (s1_item),
    .subkey   ({subkey_high_r, subkey_low_r}),
    .out_busy (out_busy),
    .adv      (adv),
    .res      (res)
  );

  // Output register
  always_comb begin
    if (res.res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res.res_valid) begin
      out_data_r.hash_high <= res.res_hash[127:64];
      out_data_r.hash_low  <= res.res_hash[63:0];
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // A new hash never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    res.res_valid |-> !(out_valid_r && !out_ready))
    else $error("hash result overwrote a pending output");

  // Output valid only rises after a finalize went through the core
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(res.res_valid))
    else $error("output valid without a finalize");

  // Back-pressure on the input only with a held item
  a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (s1_valid && s1_item.fin && out_busy))
    else $error("input stalled without a blocked finalize");

endmodule

FILE: test/ghash_gf128_accumulator_unit_test.sv
// Self-checking testbench for the GHASH GF(2^128) accumulator unit.
`timescale 1ns / 100ps

module ghash_gf128_accumulator_unit_test;
  import ghash_pkg::*;

  // Opcode that the block drops without effect
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int unsigned NUM_PHASES = 9;
  localparam int unsigned PHASE_ITEMS = 190;
  localparam int unsigned HOLDOFF_CYCLES = 400;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_data;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_SUBKEY_HIGH;
  logic [63:0] cfg_wdata = '0;

  // Predictor state: subkey H, running hash and the section byte totals
  logic [127:0] subkey_h = '0;
  logic [127:0] hash_acc = '0;
  logic [TOTAL_W-1:0] aad_bytes = '0;
  logic [TOTAL_W-1:0] text_bytes = '0;

  in_item_t pending_items[$];
  out_item_t expected_hashes[$];
  int unsigned queued_count = 0;
  int unsigned items_taken = 0;
  int unsigned errors = 0;
  int unsigned idle_pct = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned holdoff_requests = 0;
  int unsigned holdoffs_served = 0;
  int unsigned holdoff_left = 0;

  ghash_gf128_accumulator_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // GF(2^128) product in GCM bit order (bit 127 is x^0), reduction by 0xe1
  function automatic logic [127:0] gf128_mul(logic [127:0] x, logic [127:0] h);
    logic [127:0] z;
    logic [127:0] v;
    z = '0;
    v = h;
    for (int i = 0; i < 128; i++) begin
      if (x[127-i]) z ^= v;
      v = v[0] ? ((v >> 1) ^ {8'he1, 120'b0}) : (v >> 1);
    end
    return z;
  endfunction

  // Update the running hash for one accepted transaction
  task automatic ghash_absorb_item(in_item_t it);
    logic [127:0] mask;
    int unsigned n;
    case (it.opcode) inside
      OP_FINAL: begin
        hash_acc = gf128_mul(hash_acc ^ {aad_bytes, 3'b000, text_bytes, 3'b000}, subkey_h);
        expected_hashes.push_back('{hash_high: hash_acc[127:64], hash_low: hash_acc[63:0]});
        hash_acc = '0;
        aad_bytes = '0;
        text_bytes = '0;
      end
      OP_AAD, OP_TEXT: begin
        if (it.valid_bytes != 0) begin
          n = (it.valid_bytes > BLK_BYTES) ? BLK_BYTES : it.valid_bytes;
          mask = {128{1'b1}} << (8 * (BLK_BYTES - n));
          hash_acc = gf128_mul(hash_acc ^ ({it.block_high, it.block_low} & mask), subkey_h);
          if (it.opcode == OP_AAD) aad_bytes += n;
          else text_bytes += n;
        end
      end
      default: ;
    endcase
  endtask

  task automatic queue_item(logic [1:0] op, logic [63:0] hi, logic [63:0] lo,
                            logic [4:0] nbytes);
    in_item_t it;
    it.opcode = op;
    it.block_high = hi;
    it.block_low = lo;
    it.valid_bytes = nbytes;
    pending_items.push_back(it);
    queued_count++;
  endtask

  // Half-block data, biased toward all-zero and all-one words
  function automatic logic [63:0] rand_half();
    case ($urandom_range(9, 0))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic note_failure(string what, out_item_t want, out_item_t got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("%0t: %s: expected %h_%h, got %h_%h", $realtime, what,
               want.hash_high, want.hash_low, got.hash_high, got.hash_low);
  endtask

  // Input driver: offers queued items, inserts idle bursts between them
  always @(posedge clk) begin : driver
    in_item_t next_item;
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      next_item = in_data;
      if (in_valid && in_ready) begin
        ghash_absorb_item(in_data);
        items_taken++;
        next_valid = 1'b0;
      end
      if (!next_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
          send_gap = $urandom_range(18, 0);
        end else if (pending_items.size() != 0) begin
          next_item = pending_items.pop_front();
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
      in_data <= next_item;
    end
  end

  // Result monitor: checks each hash transaction, drives out_ready stalls
  always @(posedge clk) begin : monitor
    out_item_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_hashes.size() == 0) begin
          note_failure("unexpected hash", '0, out_data);
        end else begin
          want = expected_hashes.pop_front();
          if (want.hash_high != out_data.hash_high || want.hash_low != out_data.hash_low)
            note_failure("hash mismatch", want, out_data);
        end
      end
      // long hold-off so the block backs up into its input
      if (holdoffs_served != holdoff_requests) begin
        holdoffs_served++;
        holdoff_left = HOLDOFF_CYCLES;
      end
      if (holdoff_left > 0) begin
        holdoff_left--;
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else if (idle_pct != 0 && $urandom_range(99, 0) < idle_pct) begin
        recv_gap = $urandom_range(18, 0);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus: reset, then one phase per subkey setting
  initial begin : stimulus
    logic [127:0] h;
    int unsigned phase_start;
    int unsigned n_aad;
    int unsigned n_text;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0: h = 128'h66e94bd4ef8a2c3b884cfa59ca342b2e;
        1: h = '0;
        2: h = '1;
        3: h = {1'b1, 127'b0};  // multiplicative identity in GCM order
        4: h = 128'h1;
        default: h = {$urandom, $urandom, $urandom, $urandom};
      endcase
      idle_pct = (phase == 3 || phase == NUM_PHASES - 1) ? 0 : $urandom_range(40, 5);

      // subkey load while the block is idle
      @(posedge clk);
      cfg_we <= 1'b1;
      cfg_index <= REG_SUBKEY_HIGH;
      cfg_wdata <= h[127:64];
      @(posedge clk);
      cfg_index <= REG_SUBKEY_LOW;
      cfg_wdata <= h[63:0];
      @(posedge clk);
      cfg_we <= 1'b0;
      subkey_h = h;

      if (phase == 5) begin
        idle_pct = 0;
        holdoff_requests++;
      end

      if (phase == 0) begin
        // empty message, with junk in the ignored finalize fields
        queue_item(OP_FINAL, '1, '1, 5'd31);
        // partial lengths at the byte and half boundaries
        queue_item(OP_AAD, '1, '1, 5'd16);
        queue_item(OP_AAD, '1, '1, 5'd1);
        queue_item(OP_AAD, '1, '1, 5'd8);
        queue_item(OP_AAD, '1, '1, 5'd9);
        queue_item(OP_AAD, '1, '1, 5'd15);
        queue_item(OP_TEXT, '1, '1, 5'd16);
        // zero count and unknown opcode are dropped; counts above 16 clamp
        queue_item(OP_TEXT, '1, '1, 5'd0);
        queue_item(OP_TEXT, '1, '1, 5'd17);
        queue_item(OP_TEXT, '1, '1, 5'd31);
        queue_item(OP_NONE, '1, '1, 5'd16);
        queue_item(OP_FINAL, '0, '0, 5'd0);
        // ciphertext ahead of AAD, partial block mid-section
        queue_item(OP_TEXT, 64'h0123456789abcdef, 64'hfedcba9876543210, 5'd7);
        queue_item(OP_AAD, 64'h5555555555555555, 64'haaaaaaaaaaaaaaaa, 5'd12);
        queue_item(OP_AAD, '0, '0, 5'd16);
        queue_item(OP_TEXT, 64'haaaaaaaaaaaaaaaa, 64'h5555555555555555, 5'd2);
        queue_item(OP_FINAL, '0, '0, 5'd16);
        // section with all-zero data
        queue_item(OP_AAD, '0, '0, 5'd16);
        queue_item(OP_TEXT, '0, '0, 5'd5);
        queue_item(OP_FINAL, '1, '0, 5'd1);
      end else begin
        phase_start = queued_count;
        while (queued_count - phase_start < PHASE_ITEMS) begin
          if ($urandom_range(9, 0) < 8) begin
            // well-formed message: AAD, then ciphertext, last block of each may be partial
            n_aad = $urandom_range(4, 0);
            n_text = $urandom_range(6, 0);
            for (int k = 0; k < n_aad; k++)
              queue_item(OP_AAD, rand_half(), rand_half(),
                         (k == n_aad - 1) ? 5'($urandom_range(16, 1)) : 5'd16);
            for (int k = 0; k < n_text; k++)
              queue_item(OP_TEXT, rand_half(), rand_half(),
                         (k == n_text - 1) ? 5'($urandom_range(16, 1)) : 5'd16);
            queue_item(OP_FINAL, rand_half(), rand_half(), 5'($urandom_range(31, 0)));
          end else begin
            // noise: any opcode, any count
            repeat ($urandom_range(4, 1))
              queue_item(2'($urandom_range(3, 0)), rand_half(), rand_half(),
                         5'($urandom_range(31, 0)));
          end
        end
      end

      // drain: every item taken and every hash returned, then let the pipe settle
      while (items_taken != queued_count || expected_hashes.size() != 0) @(posedge clk);
      repeat (SETTLE_CYCLES) @(posedge clk);
    end

    if (errors == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #1000000;
    $display("simulation failed");
    $finish;
  end

endmodule

FILE: files.f
src/ghash_pkg.sv
src/ghash_gfmul.sv
src/ghash_in_stage.sv
src/ghash_core.sv
src/ghash_gf128_accumulator_unit.sv
test/ghash_gf128_accumulator_unit_test.sv
